// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define WDT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("watchdog check failed");

// next-cycle implication
`define WDT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("watchdog check failed");

`endif

// ----- src/wdt_pkg.sv -----
package wdt_pkg;

  localparam int DEF_COUNT_WIDTH = 32;
  localparam logic [31:0] MAGIC_UNLOCK = 32'h1ACC_E551;
  localparam int STALL_BIT = 8;
  localparam int CTRL_INT_EN_BIT = 0;
  localparam int CTRL_RST_EN_BIT = 1;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    REG_LOAD      = 3'd0,
    REG_VALUE     = 3'd1,
    REG_CONTROL   = 3'd2,
    REG_INTCLEAR  = 3'd3,
    REG_RAWSTATUS = 3'd4,
    REG_TEST      = 3'd5,
    REG_LOCK      = 3'd6
  } reg_sel_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  reg_sel;
    logic [31:0] write_data;
    logic        debug_halt;
  } cmd_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
    logic        reset_out;
    logic        is_locked;
  } rsp_t;

endpackage

// ----- src/wdt_cmd_if.sv -----
interface wdt_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [2:0]  reg_sel;
  logic [31:0] write_data;
  logic        debug_halt;

  modport source (output valid, opcode, reg_sel, write_data, debug_halt, input ready);
  modport sink (input valid, opcode, reg_sel, write_data, debug_halt, output ready);
endinterface

// ----- src/wdt_rsp_if.sv -----
interface wdt_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq;
  logic        reset_out;
  logic        is_locked;

  modport source (output valid, read_data, irq, reset_out, is_locked, input ready);
  modport sink (input valid, read_data, irq, reset_out, is_locked, output ready);
endinterface

// ----- src/wdt_regs.sv -----
module wdt_regs
  import wdt_pkg::*;
#(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  cmd_t cmd,
  output rsp_t res
);

  logic [COUNT_WIDTH-1:0] period, period_next;
  logic [COUNT_WIDTH-1:0] count, count_next;
  logic [COUNT_WIDTH-1:0] load_val;
  logic [31:0]            count_rd;
  logic [31:0]            period_rd;
  logic raw_status, raw_status_next;
  logic int_enable, int_enable_next;
  logic reset_enable, reset_enable_next;
  logic debug_stall, debug_stall_next;
  logic lock_flag, lock_flag_next;
  logic reset_latched, reset_latched_next;
  logic [31:0] rd;

  if (COUNT_WIDTH >= 32) begin : g_wide
    assign count_rd  = count[31:0];
    assign period_rd = period[31:0];
  end else begin : g_narrow
    assign count_rd  = {{(32-COUNT_WIDTH){1'b0}}, count};
    assign period_rd = {{(32-COUNT_WIDTH){1'b0}}, period};
  end

  if (COUNT_WIDTH > 32) begin : g_load_ext
    assign load_val = {{(COUNT_WIDTH-32){1'b0}}, cmd.write_data};
  end else begin : g_load_cut
    assign load_val = cmd.write_data[COUNT_WIDTH-1:0];
  end

  always_comb begin
    period_next        = period;
    count_next         = count;
    raw_status_next    = raw_status;
    int_enable_next    = int_enable;
    reset_enable_next  = reset_enable;
    debug_stall_next   = debug_stall;
    lock_flag_next     = lock_flag;
    reset_latched_next = reset_latched;
    rd                 = '0;
    case (opcode_t'(cmd.opcode))
      OP_TICK: begin
        if (!(debug_stall && cmd.debug_halt)) begin
          if (count[COUNT_WIDTH-1:1] == '0) begin
            if (raw_status && reset_enable) reset_latched_next = 1'b1;
            raw_status_next = 1'b1;
            count_next      = period;
          end else begin
            count_next = count - COUNT_WIDTH'(1);
          end
        end
      end
      OP_WRITE: begin
        if (reg_sel_t'(cmd.reg_sel) == REG_LOCK) begin
          lock_flag_next = (cmd.write_data != MAGIC_UNLOCK);
        end else if (!lock_flag) begin
          case (reg_sel_t'(cmd.reg_sel))
            REG_LOAD: begin
              period_next = load_val;
              count_next  = load_val;
            end
            REG_CONTROL: begin
              if (cmd.write_data[CTRL_INT_EN_BIT] && !int_enable) begin
                int_enable_next = 1'b1;
                count_next      = period;
              end
              reset_enable_next = cmd.write_data[CTRL_RST_EN_BIT];
            end
            REG_INTCLEAR: begin
              raw_status_next = 1'b0;
              count_next      = period;
            end
            REG_TEST: debug_stall_next = cmd.write_data[STALL_BIT];
            default: ;
          endcase
        end
      end
      OP_READ: begin
        case (reg_sel_t'(cmd.reg_sel))
          REG_LOAD:      rd = period_rd;
          REG_VALUE:     rd = count_rd;
          REG_CONTROL: begin
            rd[CTRL_INT_EN_BIT] = int_enable;
            rd[CTRL_RST_EN_BIT] = reset_enable;
          end
          REG_RAWSTATUS: rd[0] = raw_status;
          REG_TEST:      rd[STALL_BIT] = debug_stall;
          REG_LOCK:      rd[0] = lock_flag;
          default:       rd = '0;
        endcase
      end
      default: ;
    endcase
  end

  assign res.read_data = rd;
  assign res.irq       = raw_status_next && int_enable_next;
  assign res.reset_out = reset_latched_next;
  assign res.is_locked = lock_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      period        <= '1;
      count         <= '1;
      raw_status    <= 1'b0;
      int_enable    <= 1'b0;
      reset_enable  <= 1'b0;
      debug_stall   <= 1'b0;
      lock_flag     <= 1'b0;
      reset_latched <= 1'b0;
    end else if (accept) begin
      period        <= period_next;
      count         <= count_next;
      raw_status    <= raw_status_next;
      int_enable    <= int_enable_next;
      reset_enable  <= reset_enable_next;
      debug_stall   <= debug_stall_next;
      lock_flag     <= lock_flag_next;
      reset_latched <= reset_latched_next;
    end
  end

endmodule

// ----- src/wdt_outbuf.sv -----
module wdt_outbuf
  import wdt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rsp_t res,
  output logic can_push,
  wdt_rsp_if.source rsp
);

  logic main_valid;
  rsp_t main_data;
  logic skid_valid;
  rsp_t skid_data;

  assign can_push = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (rsp.ready || !main_valid) begin
      main_valid <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.ready || !main_valid) begin
      main_data <= skid_valid ? skid_data : res;
    end else if (push) begin
      skid_data <= res;
    end
  end

  assign rsp.valid     = main_valid;
  assign rsp.read_data = main_data.read_data;
  assign rsp.irq       = main_data.irq;
  assign rsp.reset_out = main_data.reset_out;
  assign rsp.is_locked = main_data.is_locked;

endmodule

// ----- src/lockable_two_stage_watchdog_core.sv -----
// Lockable two-stage watchdog: one beat per clock on the command channel when it is not
// stalled (tick, register write or register read) and exactly one response beat per
// command, in order, registered after acceptance; it waits behind an earlier response.
// The watchdog state is updated in the cycle a command is accepted, so commands may
// follow back to back; a two-entry output buffer lets one further command in while a
// response waits, and the command side stalls only when both entries are full.
module lockable_two_stage_watchdog_core
  import wdt_pkg::*;
#(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input logic clk,
  input logic rst,
  wdt_cmd_if.sink   cmd,
  wdt_rsp_if.source rsp
);

  logic accept;
  logic can_push;
  cmd_t cmd_word;
  rsp_t res;

  assign cmd.ready = can_push;
  assign accept    = cmd.valid && can_push;

  assign cmd_word.opcode     = cmd.opcode;
  assign cmd_word.reg_sel    = cmd.reg_sel;
  assign cmd_word.write_data = cmd.write_data;
  assign cmd_word.debug_halt = cmd.debug_halt;

  wdt_regs #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_regs (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .cmd   (cmd_word),
    .res   (res)
  );

  wdt_outbuf u_outbuf (
    .clk     (clk),
    .rst     (rst),
    .push    (accept),
    .res     (res),
    .can_push(can_push),
    .rsp     (rsp)
  );

endmodule

// ----- src/wdt_checker.sv -----
`include "assert_macros.svh"

module wdt_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] rsp_read_data,
  input logic        rsp_irq,
  input logic        rsp_reset_out,
  input logic        rsp_is_locked
);

  // stalled response beat holds
  `WDT_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready,
    rsp_valid && $stable(rsp_read_data) && $stable(rsp_irq) && $stable(rsp_reset_out)
    && $stable(rsp_is_locked))

  // every accepted command is followed next cycle by a valid response beat
  `WDT_ASSERT_NEXT(a_cmd_to_rsp, clk, rst, cmd_valid && cmd_ready, rsp_valid)

  // reset output is sticky across responses
  `WDT_ASSERT_NEXT(a_reset_sticky, clk, rst, rsp_valid && rsp_reset_out,
    !rsp_valid || rsp_reset_out)

  // commands only back up behind a pending response
  `WDT_ASSERT_NOW(a_stall_reason, clk, rst, !cmd_ready, rsp_valid)

endmodule

bind lockable_two_stage_watchdog_core wdt_checker u_wdt_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_read_data(rsp.read_data),
  .rsp_irq      (rsp.irq),
  .rsp_reset_out(rsp.reset_out),
  .rsp_is_locked(rsp.is_locked)
);
